// ===== rtl/lhc_pkg.sv =====
`default_nettype none
package lhc_pkg;
  localparam int unsigned Capacity = 100;
  localparam int unsigned RankW = $clog2(Capacity);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CmdProbe  = 2'd0;
  localparam cmd_t CmdGet    = 2'd1;
  localparam cmd_t CmdInsert = 2'd2;

  // Broadcast from the controller to every cell for one operation step.
  typedef struct packed {
    logic             lookup;   // never set; cells compare the key on every step
    logic             touch;    // matched entry becomes most recent
    logic             insert;   // new key: age all, fill target cell
    logic             evict;    // target cell is the least recent entry
    logic [RankW-1:0] ref_rank; // rank of the touched entry
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/lhc_if.sv =====
`default_nettype none
interface lhc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] key;
  logic [63:0] handle_in;
  modport source (output valid, command, key, handle_in, input ready);
  modport sink   (input valid, command, key, handle_in, output ready);
endinterface

interface lhc_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] handle_out;
  logic        evicted;
  logic [63:0] evicted_key;
  logic [63:0] evicted_handle;
  modport source (output valid, status, handle_out, evicted, evicted_key,
                  evicted_handle, input ready);
  modport sink   (input valid, status, handle_out, evicted, evicted_key,
                  evicted_handle, output ready);
endinterface
`default_nettype wire

// ===== rtl/lhc_cell.sv =====
`default_nettype none
// One table entry. Handles its own compare and rank update, and passes the
// free-slot claim, the hit data and the oldest-entry data down the chain.
module lhc_cell (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire lhc_pkg::cell_ctl_t   ctl_i,
  input  wire [63:0]                key_i,
  input  wire [63:0]                handle_i,
  input  wire [lhc_pkg::RankW-1:0]  oldest_rank_i,
  // chain in from the previous cell
  input  wire                       free_seen_i,
  input  wire                       hit_i,
  input  wire [63:0]                hit_handle_i,
  input  wire [lhc_pkg::RankW-1:0]  hit_rank_i,
  input  wire [63:0]                old_key_i,
  input  wire [63:0]                old_handle_i,
  // chain out to the next cell
  output logic                      free_seen_o,
  output logic                      hit_o,
  output logic [63:0]               hit_handle_o,
  output logic [lhc_pkg::RankW-1:0] hit_rank_o,
  output logic [63:0]               old_key_o,
  output logic [63:0]               old_handle_o
);
  logic                      valid_q, valid_d;
  logic [lhc_pkg::RankW-1:0] rank_q, rank_d;
  logic [63:0]               key_q, handle_q;
  logic                      match, is_oldest, fill;

  assign match     = valid_q && (key_q == key_i);
  assign is_oldest = valid_q && (rank_q == oldest_rank_i);
  // Only the first free cell claims an insert; with no free cell the
  // least recent one is replaced.
  assign fill = ctl_i.insert &&
                ((!valid_q && !free_seen_i) || (ctl_i.evict && is_oldest));

  always_comb begin
    free_seen_o  = free_seen_i || !valid_q;
    hit_o        = hit_i || match;
    hit_handle_o = match ? handle_q : hit_handle_i;
    hit_rank_o   = match ? rank_q : hit_rank_i;
    old_key_o    = is_oldest ? key_q : old_key_i;
    old_handle_o = is_oldest ? handle_q : old_handle_i;
    valid_d = valid_q;
    rank_d  = rank_q;
    if (ctl_i.touch && valid_q) begin
      if (match) rank_d = '0;
      else if (rank_q < ctl_i.ref_rank) rank_d = rank_q + 1'b1;
    end
    if (ctl_i.insert) begin
      if (fill) begin
        valid_d = 1'b1;
        rank_d  = '0;
      end else if (valid_q) begin
        rank_d = rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill) begin
      key_q    <= key_i;
      handle_q <= handle_i;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lhc_chain.sv =====
`default_nettype none
// Row of cells with the daisy chains tied off at the head.
module lhc_chain (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire lhc_pkg::cell_ctl_t   ctl_i,
  input  wire [63:0]                key_i,
  input  wire [63:0]                handle_i,
  input  wire [lhc_pkg::RankW-1:0]  oldest_rank_i,
  output logic                      full_o,
  output logic                      hit_o,
  output logic [63:0]               hit_handle_o,
  output logic [lhc_pkg::RankW-1:0] hit_rank_o,
  output logic [63:0]               old_key_o,
  output logic [63:0]               old_handle_o
);
  localparam int unsigned N = lhc_pkg::Capacity;
  logic                      fs [N+1];
  logic                      ht [N+1];
  logic [63:0]               hh [N+1];
  logic [lhc_pkg::RankW-1:0] hr [N+1];
  logic [63:0]               ok [N+1];
  logic [63:0]               oh [N+1];

  assign fs[0] = 1'b0;
  assign ht[0] = 1'b0;
  assign hh[0] = '0;
  assign hr[0] = '0;
  assign ok[0] = '0;
  assign oh[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lhc_cell u_cell (
      .clk_i, .rst_ni, .ctl_i, .key_i, .handle_i, .oldest_rank_i,
      .free_seen_i(fs[g]), .hit_i(ht[g]), .hit_handle_i(hh[g]),
      .hit_rank_i(hr[g]), .old_key_i(ok[g]), .old_handle_i(oh[g]),
      .free_seen_o(fs[g+1]), .hit_o(ht[g+1]), .hit_handle_o(hh[g+1]),
      .hit_rank_o(hr[g+1]), .old_key_o(ok[g+1]), .old_handle_o(oh[g+1])
    );
  end

  assign full_o       = !fs[N];
  assign hit_o        = ht[N];
  assign hit_handle_o = hh[N];
  assign hit_rank_o   = hr[N];
  assign old_key_o    = ok[N];
  assign old_handle_o = oh[N];
endmodule
`default_nettype wire

// ===== rtl/lru_handle_cache.sv =====
`default_nettype none
// Channel | Dir | Payload
// req     | in  | command, key, handle_in
// rsp     | out | status, handle_out, evicted, evicted_key, evicted_handle
// An item is accepted in StIdle, compared in StCmp, whose closing edge also
// writes ranks and, on insert, the target cell, and then offered as a
// registered result in StOut.
// The entry count is tracked here, so the least recent rank is count-1.
// Reset empties the table at once. A stalled result holds the block; the
// next item is taken in the cycle after the result leaves.
module lru_handle_cache (
  input  wire       clk_i,
  input  wire       rst_ni,
  lhc_req_if.sink   req,
  lhc_rsp_if.source rsp
);
  typedef enum logic [1:0] {StIdle, StCmp, StOut} state_e;
  state_e state_q;
  lhc_pkg::cmd_t cmd_q;
  logic [63:0] key_q, handle_q;
  logic [lhc_pkg::RankW:0] count_q;
  logic [lhc_pkg::RankW-1:0] oldest_rank;
  lhc_pkg::cell_ctl_t ctl;
  logic full, hit;
  logic [63:0] hit_handle, old_key, old_handle;
  logic [lhc_pkg::RankW-1:0] hit_rank;
  logic rst_q, ev_q;
  logic [63:0] hnd_o_q, evk_q, evh_q;

  assign oldest_rank = lhc_pkg::RankW'(count_q - 1'b1);

  always_comb begin
    ctl = '0;
    if (state_q == StCmp) begin
      ctl.ref_rank = hit_rank;
      if (hit && (cmd_q == lhc_pkg::CmdGet || cmd_q == lhc_pkg::CmdInsert))
        ctl.touch = 1'b1;
      if (!hit && cmd_q == lhc_pkg::CmdInsert) begin
        ctl.insert = 1'b1;
        ctl.evict  = full;
      end
    end
  end

  lhc_chain u_chain (
    .clk_i, .rst_ni, .ctl_i(ctl), .key_i(key_q), .handle_i(handle_q),
    .oldest_rank_i(oldest_rank), .full_o(full), .hit_o(hit),
    .hit_handle_o(hit_handle), .hit_rank_o(hit_rank),
    .old_key_o(old_key), .old_handle_o(old_handle)
  );

  assign req.ready = (state_q == StIdle);
  assign rsp.valid = (state_q == StOut);
  assign rsp.status = rst_q;
  assign rsp.handle_out = hnd_o_q;
  assign rsp.evicted = ev_q;
  assign rsp.evicted_key = evk_q;
  assign rsp.evicted_handle = evh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      rst_q   <= 1'b0;
      ev_q    <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: if (req.valid) state_q <= StCmp;
        StCmp: begin
          state_q <= StOut;
          rst_q   <= !(hit || cmd_q == lhc_pkg::CmdInsert);
          ev_q    <= ctl.insert && full;
          if (ctl.insert && !full) count_q <= count_q + 1'b1;
        end
        StOut: if (rsp.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      cmd_q    <= req.command;
      key_q    <= req.key;
      handle_q <= req.handle_in;
    end
    if (state_q == StCmp) begin
      hnd_o_q <= (hit && cmd_q == lhc_pkg::CmdGet) ? hit_handle : '0;
      evk_q   <= (ctl.insert && full) ? old_key : '0;
      evh_q   <= (ctl.insert && full) ? old_handle : '0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lhc_checker.sv =====
`default_nettype none
module lhc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire        status_i,
  input wire        evicted_i,
  input wire [63:0] handle_out_i,
  input wire [63:0] evicted_key_i
);
  // One item in flight at most.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("accept while result pending");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> ##1 out_valid_i) else $error("late result");
  a_miss_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> handle_out_i == '0 && !evicted_i)
    else $error("miss with data");
  a_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !evicted_i |-> evicted_key_i == '0) else $error("stray key");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
    else $error("result dropped");
endmodule

bind lru_handle_cache lhc_checker u_lhc_checker (
  .clk_i, .rst_ni, .in_valid_i(req.valid), .in_ready_i(req.ready),
  .out_valid_i(rsp.valid), .out_ready_i(rsp.ready), .status_i(rsp.status),
  .evicted_i(rsp.evicted), .handle_out_i(rsp.handle_out),
  .evicted_key_i(rsp.evicted_key)
);
`default_nettype wire

// ===== tb/sv/lru_handle_cache_test.sv =====
`timescale 1ns / 1ps
module lru_handle_cache_test;

  typedef struct {
    logic        status;
    logic [63:0] handle_out;
    logic        evicted;
    logic [63:0] evicted_key;
    logic [63:0] evicted_handle;
  } lookup_result_t;

  // Predicts the table and keeps the results still owed by the block.
  class lru_table_board;
    bit          used_q[lhc_pkg::Capacity];
    logic [63:0] key_q[lhc_pkg::Capacity];
    logic [63:0] handle_q[lhc_pkg::Capacity];
    int unsigned rank_q[lhc_pkg::Capacity];
    lookup_result_t owed_q[$];
    int          mismatch_count;

    function new();
      foreach (used_q[i]) begin
        used_q[i] = 0;
        rank_q[i] = 0;
      end
      mismatch_count = 0;
    endfunction

    function int find_key(logic [63:0] k);
      foreach (used_q[i]) begin
        if (used_q[i] && key_q[i] == k) return i;
      end
      return -1;
    endfunction

    function void make_recent(int s);
      int unsigned r;
      r = rank_q[s];
      foreach (used_q[i]) begin
        if (used_q[i] && rank_q[i] < r) rank_q[i]++;
      end
      rank_q[s] = 0;
    endfunction

    function void note_request(lhc_pkg::cmd_t cmd, logic [63:0] k, logic [63:0] h);
      lookup_result_t res;
      int s;
      int free_slot;
      int oldest;
      res = '{1'b1, 64'd0, 1'b0, 64'd0, 64'd0};
      s = find_key(k);
      if (cmd == lhc_pkg::CmdGet) begin
        if (s >= 0) begin
          res.status = 0;
          res.handle_out = handle_q[s];
          make_recent(s);
        end
      end else if (cmd == lhc_pkg::CmdInsert) begin
        res.status = 0;
        if (s >= 0) begin
          make_recent(s);
        end else begin
          free_slot = -1;
          oldest = -1;
          foreach (used_q[i]) begin
            if (!used_q[i]) begin
              if (free_slot < 0) free_slot = i;
            end else if (oldest < 0 || rank_q[i] > rank_q[oldest]) begin
              oldest = i;
            end
          end
          if (free_slot < 0) begin
            res.evicted = 1;
            res.evicted_key = key_q[oldest];
            res.evicted_handle = handle_q[oldest];
            used_q[oldest] = 0;
            free_slot = oldest;
          end
          foreach (used_q[i]) begin
            if (used_q[i]) rank_q[i]++;
          end
          used_q[free_slot] = 1;
          key_q[free_slot] = k;
          handle_q[free_slot] = h;
          rank_q[free_slot] = 0;
        end
      end else begin
        if (s >= 0) res.status = 0;
      end
      owed_q = {owed_q, res};
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t exp;
      if (owed_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result item: %p", got);
        return;
      end
      exp = owed_q.pop_front();
      if (got.status !== exp.status || got.handle_out !== exp.handle_out ||
          got.evicted !== exp.evicted || got.evicted_key !== exp.evicted_key ||
          got.evicted_handle !== exp.evicted_handle) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Result differs: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  lhc_req_if req ();
  lhc_rsp_if rsp ();
  lru_table_board board;
  int     cycle_count;
  bit     stall_free;
  bit     hold_off;
  logic [63:0] key_pool[16];

  lru_handle_cache dut (.clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp));

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random stalls, none in the quiet stretch, long hold-off on request.
  initial begin
    lookup_result_t got;
    rsp.ready = 0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.handle_out = rsp.handle_out;
        got.evicted = rsp.evicted;
        got.evicted_key = rsp.evicted_key;
        got.evicted_handle = rsp.evicted_handle;
        board.check_result(got);
      end
      if (!rst_ni || hold_off) rsp.ready <= 0;
      else rsp.ready <= stall_free || ($urandom_range(99) >= 31);
    end
  end

  task automatic send_request(lhc_pkg::cmd_t cmd, logic [63:0] k, logic [63:0] h);
    while (!stall_free && $urandom_range(99) < 31) begin
      req.valid <= 0;
      @(posedge clk_i);
    end
    req.valid <= 1;
    req.command <= cmd;
    req.key <= k;
    req.handle_in <= h;
    do @(posedge clk_i); while (!req.ready);
    board.note_request(cmd, k, h);
  endtask

  task automatic drain_results();
    req.valid <= 0;
    @(posedge clk_i);
    while (board.owed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(15)];
    return rand_word();
  endfunction

  initial begin
    lhc_pkg::cmd_t cmd;
    board = new();
    stall_free = 0;
    hold_off = 0;
    req.valid = 0;
    req.command = lhc_pkg::CmdProbe;
    req.key = 0;
    req.handle_in = 0;
    rst_ni = 0;
    foreach (key_pool[i]) key_pool[i] = rand_word();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: absent get and probe on an empty table, extreme keys and handles.
    send_request(lhc_pkg::CmdGet, 64'd0, 64'd0);
    send_request(lhc_pkg::CmdProbe, '1, '1);
    send_request(lhc_pkg::CmdInsert, 64'd0, '1);
    send_request(lhc_pkg::CmdInsert, '1, 64'd0);
    send_request(lhc_pkg::CmdProbe, 64'd0, 64'd5);
    send_request(lhc_pkg::CmdGet, '1, '1);
    send_request(lhc_pkg::CmdInsert, 64'd0, 64'h1234);
    send_request(lhc_pkg::CmdGet, 64'd0, 64'd0);
    send_request(lhc_pkg::cmd_t'(2'd3), '1, '1);
    send_request(lhc_pkg::CmdGet, 64'h5555_5555_5555_5555, 64'd0);
    send_request(lhc_pkg::CmdInsert, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    drain_results();

    // Fill past capacity to force evictions, with a long receiver hold-off.
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < lhc_pkg::Capacity + 20; i++) begin
        send_request(lhc_pkg::CmdInsert, 64'h100 + i, rand_word());
        if (i % 7 == 0)
          send_request(lhc_pkg::CmdGet, 64'h100 + $urandom_range(i), 64'd0);
      end
    join
    drain_results();

    // Random part: mostly pooled keys, with a stretch without idling.
    for (int n = 0; n < 550; n++) begin
      stall_free = (n >= 300 && n < 400);
      if ((n & 127) == 127) key_pool[$urandom_range(15)] = rand_word();
      cmd = lhc_pkg::cmd_t'($urandom_range(3));
      if ($urandom_range(9) < 4) cmd = lhc_pkg::CmdInsert;
      if (cmd == lhc_pkg::CmdInsert && $urandom_range(3) == 0)
        send_request(cmd, rand_word(), rand_word());
      else
        send_request(cmd, pick_key(), rand_word());
      if (n == 500) drain_results();
    end
    stall_free = 0;
    drain_results();
    repeat (10) @(posedge clk_i);

    if (board.mismatch_count == 0 && board.owed_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
